/* src/weighted_pixel_accumulator_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the weighted pixel accumulator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_PIXEL_ACCUMULATOR_UNIT_MACROS_SVH
`define WEIGHTED_PIXEL_ACCUMULATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define WPA_ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("weighted pixel accumulator check failed");

`define WPA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("weighted pixel accumulator check failed");

`define WPA_ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
		else $error("weighted pixel accumulator check failed");

`else

`define WPA_ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons)

`define WPA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`define WPA_ASSERT_NEVER(lbl, clk_s, rstn_s, cond)

`endif

`endif

/* src/wpa_pkg.sv */
// ----------------------------------------------------------------------------
// Weighted pixel accumulator package
// Field widths, register indexes, action codes and parameter defaults.
// ----------------------------------------------------------------------------
package wpa_pkg;

	localparam int DEF_MAX_WIDTH  = 128;
	localparam int DEF_MAX_HEIGHT = 128;
	localparam int DEF_SUM_BITS   = 32;

	localparam int COORD_W    = 16;
	localparam int VAL_W      = 16;
	localparam int SIZE_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int FRAC_BITS  = 8;

	localparam logic [SIZE_W-1:0] FILM_SIZE_RST = 8'd128;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_ORIGIN    = 2'd0,
		CFG_Y_ORIGIN    = 2'd1,
		CFG_FILM_WIDTH  = 2'd2,
		CFG_FILM_HEIGHT = 2'd3
	} cfg_reg_t;

	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// Lanes of one memory word.
	localparam int LANE_WEIGHT = 0;
	localparam int LANE_RED    = 1;
	localparam int NUM_LANES   = 4;

endpackage

/* src/weighted_pixel_accumulator_unit.sv */
// ----------------------------------------------------------------------------
// Weighted pixel accumulator
// Per-pixel store of weight and colour sums with normalized read-back.
// ----------------------------------------------------------------------------
// After reset the block clears its sum memory one pixel per cycle; busy stays
// high until all MAX_WIDTH*MAX_HEIGHT pixels are cleared, while configuration
// writes are taken as usual. An item is taken when start is high and busy is
// low. An out-of-bounds item ends after the index step, an add passes through
// index, memory read and read-modify-write, and a read passes through the same
// steps when the pixel is uncovered; otherwise after the memory read one shared
// compare-and-subtract unit divides the red, green and blue sums by the weight
// sum in turn, one quotient bit per cycle; a channel whose quotient saturates
// takes its full-scale value from the first compare. A result beat is shown for
// exactly one cycle with done high and cannot be held off by the receiver.
module weighted_pixel_accumulator_unit #(
	parameter int MAX_WIDTH  = wpa_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = wpa_pkg::DEF_MAX_HEIGHT,
	parameter int SUM_BITS   = wpa_pkg::DEF_SUM_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                action,
	input  logic signed [wpa_pkg::COORD_W-1:0]  pos_x,
	input  logic signed [wpa_pkg::COORD_W-1:0]  pos_y,
	input  logic [wpa_pkg::VAL_W-1:0]           sample_weight,
	input  logic [wpa_pkg::VAL_W-1:0]           red_in,
	input  logic [wpa_pkg::VAL_W-1:0]           green_in,
	input  logic [wpa_pkg::VAL_W-1:0]           blue_in,
	input  logic                                cfg_we,
	input  logic [wpa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [wpa_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                done,
	output logic                                covered,
	output logic                                out_of_bounds,
	output logic [wpa_pkg::VAL_W-1:0]           red_avg,
	output logic [wpa_pkg::VAL_W-1:0]           green_avg,
	output logic [wpa_pkg::VAL_W-1:0]           blue_avg
);

`include "weighted_pixel_accumulator_unit_macros.svh"

	localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int Q_W     = wpa_pkg::VAL_W;
	localparam int STEP_W  = $clog2(Q_W + 1);
	localparam int DIFF_W  = wpa_pkg::COORD_W + 1;
	localparam int LO_ZERO = Q_W - wpa_pkg::FRAC_BITS;
	localparam int NUM_CH  = 3;

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_INDEX  = 6'b000100,
		S_READ   = 6'b001000,
		S_UPDATE = 6'b010000,
		S_DIV    = 6'b100000
	} state_t;

	typedef logic [wpa_pkg::NUM_LANES-1:0][SUM_BITS-1:0] word_t;

	state_t state_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic done_q;

	logic signed [wpa_pkg::COORD_W-1:0] x_origin_q;
	logic signed [wpa_pkg::COORD_W-1:0] y_origin_q;
	logic [wpa_pkg::SIZE_W-1:0] film_width_q;
	logic [wpa_pkg::SIZE_W-1:0] film_height_q;

	logic action_q;
	logic signed [DIFF_W-1:0] fx_q;
	logic signed [DIFF_W-1:0] fy_q;
	logic [wpa_pkg::NUM_LANES-1:0][wpa_pkg::VAL_W-1:0] sample_q;
	logic [ADDR_W-1:0] addr_q;
	word_t rd_data_q;
	word_t sum_mem [DEPTH];

	logic [SUM_BITS-1:0] rem_q;
	logic [Q_W-1:0] lo_q;
	logic [Q_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic [1:0] chan_q;
	logic covered_q;
	logic oob_out_q;
	logic [Q_W-1:0] avg_q [NUM_CH];

	logic [wpa_pkg::SIZE_W-1:0] eff_w;
	logic [wpa_pkg::SIZE_W-1:0] eff_h;
	logic oob;
	logic [SUM_BITS-1:0] wsum;
	logic [SUM_BITS:0] div_a;
	logic [SUM_BITS:0] div_diff;
	logic div_ge;
	logic chan_done;
	logic [Q_W-1:0] chan_quo;
	logic [SUM_BITS-1:0] next_sum;
	logic [1:0] next_lane;
	logic mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	word_t mem_wdata;
	word_t upd_word;
	logic [SUM_BITS:0] lane_sum [wpa_pkg::NUM_LANES];

	// Film size above the maximum acts as the maximum.
	always_comb begin
		eff_w = ({24'b0, film_width_q} > 32'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : film_width_q;
		eff_h = ({24'b0, film_height_q} > 32'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : film_height_q;
		oob = fx_q[DIFF_W-1] || fy_q[DIFF_W-1]
			|| (fx_q[DIFF_W-2:0] >= {8'b0, eff_w})
			|| (fy_q[DIFF_W-2:0] >= {8'b0, eff_h});
	end

	// Saturating read-modify-write of all four sums.
	always_comb begin
		for (int i = 0; i < wpa_pkg::NUM_LANES; i++) begin
			lane_sum[i] = {1'b0, rd_data_q[i]} + (SUM_BITS + 1)'(sample_q[i]);
			upd_word[i] = lane_sum[i][SUM_BITS] ? {SUM_BITS{1'b1}} : lane_sum[i][SUM_BITS-1:0];
		end
	end

	// Shared divider step. Step zero compares sum >> 8 with the weight sum,
	// which tells whether the quotient saturates; later steps shift in one
	// dividend bit and produce one quotient bit.
	always_comb begin
		wsum = rd_data_q[wpa_pkg::LANE_WEIGHT];
		div_a = (step_q == '0) ? {1'b0, rem_q} : {rem_q, lo_q[Q_W-1]};
		div_diff = div_a - {1'b0, wsum};
		div_ge = !div_diff[SUM_BITS];
		chan_done = ((step_q == '0) && div_ge) || (step_q == STEP_W'(Q_W));
		chan_quo = (step_q == '0) ? {Q_W{1'b1}} : {quo_q[Q_W-2:0], div_ge};
		next_lane = 2'(chan_q + 2'd2);
		next_sum = rd_data_q[next_lane];
	end

	always_comb begin
		mem_we = (state_q == S_CLEAR) || ((state_q == S_UPDATE) && (action_q == wpa_pkg::ACT_ADD));
		mem_waddr = (state_q == S_CLEAR) ? clr_addr_q : addr_q;
		mem_wdata = (state_q == S_CLEAR) ? '0 : upd_word;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sum_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_addr_q    <= '0;
			done_q        <= 1'b0;
			x_origin_q    <= '0;
			y_origin_q    <= '0;
			film_width_q  <= wpa_pkg::FILM_SIZE_RST;
			film_height_q <= wpa_pkg::FILM_SIZE_RST;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					wpa_pkg::CFG_X_ORIGIN:    x_origin_q    <= cfg_data;
					wpa_pkg::CFG_Y_ORIGIN:    y_origin_q    <= cfg_data;
					wpa_pkg::CFG_FILM_WIDTH:  film_width_q  <= cfg_data[wpa_pkg::SIZE_W-1:0];
					wpa_pkg::CFG_FILM_HEIGHT: film_height_q <= cfg_data[wpa_pkg::SIZE_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_INDEX;
					end
				end
				S_INDEX: begin
					if (oob) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_UPDATE;
				S_UPDATE: begin
					if (action_q == wpa_pkg::ACT_ADD) begin
						state_q <= S_IDLE;
					end else if (wsum == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (chan_done && (chan_q == 2'(NUM_CH - 1))) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					action_q    <= action;
					fx_q        <= DIFF_W'(pos_x) - DIFF_W'(x_origin_q);
					fy_q        <= DIFF_W'(pos_y) - DIFF_W'(y_origin_q);
					sample_q[0] <= sample_weight;
					sample_q[1] <= red_in;
					sample_q[2] <= green_in;
					sample_q[3] <= blue_in;
				end
			end
			S_INDEX: begin
				addr_q <= ADDR_W'(fy_q[DIFF_W-2:0]) * ADDR_W'(MAX_WIDTH)
					+ ADDR_W'(fx_q[DIFF_W-2:0]);
				if (oob) begin
					covered_q <= 1'b0;
					oob_out_q <= 1'b1;
					for (int c = 0; c < NUM_CH; c++) begin
						avg_q[c] <= '0;
					end
				end
			end
			S_READ: rd_data_q <= sum_mem[addr_q];
			S_UPDATE: begin
				oob_out_q <= 1'b0;
				covered_q <= (wsum != '0);
				chan_q    <= '0;
				step_q    <= '0;
				quo_q     <= '0;
				rem_q     <= rd_data_q[wpa_pkg::LANE_RED] >> wpa_pkg::FRAC_BITS;
				lo_q      <= {rd_data_q[wpa_pkg::LANE_RED][wpa_pkg::FRAC_BITS-1:0],
					{LO_ZERO{1'b0}}};
				if (wsum == '0) begin
					for (int c = 0; c < NUM_CH; c++) begin
						avg_q[c] <= '0;
					end
				end
			end
			S_DIV: begin
				if (chan_done) begin
					avg_q[chan_q] <= chan_quo;
					chan_q <= chan_q + 1'b1;
					step_q <= '0;
					quo_q  <= '0;
					rem_q  <= next_sum >> wpa_pkg::FRAC_BITS;
					lo_q   <= {next_sum[wpa_pkg::FRAC_BITS-1:0], {LO_ZERO{1'b0}}};
				end else begin
					step_q <= step_q + 1'b1;
					if (step_q != '0) begin
						rem_q <= div_ge ? div_diff[SUM_BITS-1:0] : div_a[SUM_BITS-1:0];
						lo_q  <= {lo_q[Q_W-2:0], 1'b0};
						quo_q <= chan_quo;
					end
				end
			end
			default: ;
		endcase
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign covered       = covered_q;
	assign out_of_bounds = oob_out_q;
	assign red_avg       = avg_q[0];
	assign green_avg     = avg_q[1];
	assign blue_avg      = avg_q[2];

	`WPA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`WPA_ASSERT_IMPLIES(a_oob_zero, clk, arst_n, done && out_of_bounds, !covered && (red_avg == '0) && (green_avg == '0) && (blue_avg == '0))
	`WPA_ASSERT_IMPLIES(a_uncovered_zero, clk, arst_n, done && !covered, (red_avg == '0) && (green_avg == '0) && (blue_avg == '0))
	`WPA_ASSERT_IMPLIES(a_done_origin, clk, arst_n, done, ($past(state_q) == S_INDEX) || ($past(state_q) == S_UPDATE) || ($past(state_q) == S_DIV))
	`WPA_ASSERT_NEVER(a_step_range, clk, arst_n, (state_q == S_DIV) && (step_q > STEP_W'(Q_W)))

endmodule
